// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/fcrc_pkg.sv
// Shared constants, operation codes and interface structs of the frame capture block.
// No dependencies.
`default_nettype none

package fcrc_pkg;

	localparam int FRAME_BYTES  = 324;
	localparam int REPORT_BYTES = 64;
	localparam int PART_COUNT   = 7;

	localparam int BYTE_W      = 8;
	localparam int PART_W      = 3;
	localparam int VALID_BIT   = 6;
	localparam int PIXEL_SHIFT = 2;

	localparam int ADDR_W   = $clog2(FRAME_BYTES);
	localparam int WPOS_W   = $clog2(FRAME_BYTES + 1);
	localparam int KIDX_W   = $clog2(REPORT_BYTES);
	localparam int PIX_SPAN = (REPORT_BYTES - 1) * (PART_COUNT - 1);
	localparam int POS_MAX  = (PIX_SPAN > FRAME_BYTES) ? PIX_SPAN : FRAME_BYTES;
	localparam int POS_W    = $clog2(POS_MAX + 1);

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_PIXEL  = 2'd1,
		OP_MOTION = 2'd2,
		OP_REPORT = 2'd3
	} op_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [BYTE_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic busy;
		logic part_zero;
	} seq_status_t;

endpackage

`default_nettype wire

// File: rtl/core/fcrc_pixel_store.sv
// Pixel frame memory with one write and one registered read port per cycle.
// Runs a clearing sweep after reset. Depends on fcrc_pkg.
`default_nettype none

module fcrc_pixel_store (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire fcrc_pkg::ram_req_t              req,
	output logic     [fcrc_pkg::BYTE_W-1:0]      rd_data,
	output logic                                 clearing
);

	logic [fcrc_pkg::BYTE_W-1:0] mem_q [fcrc_pkg::FRAME_BYTES];
	logic [fcrc_pkg::BYTE_W-1:0] rd_data_q;
	logic [fcrc_pkg::ADDR_W-1:0] clr_q;
	logic                        clearing_q;

	logic                        we;
	logic [fcrc_pkg::ADDR_W-1:0] waddr;
	logic [fcrc_pkg::BYTE_W-1:0] wdata;

	always_comb begin
		if (clearing_q) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else begin
			we    = req.we;
			waddr = req.waddr;
			wdata = req.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_q == fcrc_pkg::ADDR_W'(fcrc_pkg::FRAME_BYTES - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_data_q <= mem_q[req.raddr];
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

`default_nettype wire

// File: rtl/core/fcrc_report_seq.sv
// Report sequencer: part counter, memory read stage and output register.
// Depends on fcrc_pkg.
`default_nettype none

module fcrc_report_seq (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic     [fcrc_pkg::BYTE_W-1:0]   motion_x,
	input  wire logic     [fcrc_pkg::BYTE_W-1:0]   motion_y,
	input  wire logic     [fcrc_pkg::BYTE_W-1:0]   rd_data,
	output logic          [fcrc_pkg::ADDR_W-1:0]   raddr,
	output fcrc_pkg::seq_status_t                  status,
	output logic                                   byte_valid,
	input  wire logic                              byte_ready,
	output logic          [fcrc_pkg::BYTE_W-1:0]   report_byte,
	output logic                                   last
);

	typedef enum logic [2:0] {
		SRC_RAM,
		SRC_ZERO,
		SRC_MX,
		SRC_MY,
		SRC_PART
	} src_t;

	logic [fcrc_pkg::PART_W-1:0] part_q;
	logic [fcrc_pkg::POS_W-1:0]  base_q;
	logic [fcrc_pkg::PART_W-1:0] rep_part_q;
	logic                        rep_motion_q;
	logic                        fetch_q;
	logic [fcrc_pkg::POS_W-1:0]  pos_q;
	logic [fcrc_pkg::KIDX_W-1:0] k_q;

	logic                        valid_s1;
	src_t                        src_s1;
	logic [fcrc_pkg::ADDR_W-1:0] addr_s1;

	logic                        out_valid_q;
	logic [fcrc_pkg::BYTE_W-1:0] out_byte_q;
	logic                        out_last_q;

	logic                        motion_now;
	logic                        out_load;
	logic                        s1_adv;
	logic                        in_frame;
	logic [fcrc_pkg::ADDR_W-1:0] fetch_addr;
	src_t                        fetch_src;
	logic [fcrc_pkg::BYTE_W-1:0] src_byte;

	assign motion_now = (part_q >= fcrc_pkg::PART_W'(fcrc_pkg::PART_COUNT - 1));
	assign out_load   = valid_s1 && (!out_valid_q || byte_ready);
	assign s1_adv     = !valid_s1 || out_load;
	assign in_frame   = (pos_q < fcrc_pkg::POS_W'(fcrc_pkg::FRAME_BYTES));
	assign fetch_addr = in_frame ? pos_q[fcrc_pkg::ADDR_W-1:0] : '0;
	assign raddr      = s1_adv ? fetch_addr : addr_s1;

	always_comb begin
		if (k_q == fcrc_pkg::KIDX_W'(fcrc_pkg::REPORT_BYTES - 1)) begin
			fetch_src = SRC_PART;
		end else if (!rep_motion_q) begin
			fetch_src = in_frame ? SRC_RAM : SRC_ZERO;
		end else if (k_q == '0) begin
			fetch_src = SRC_MX;
		end else if (k_q == fcrc_pkg::KIDX_W'(1)) begin
			fetch_src = SRC_MY;
		end else begin
			fetch_src = SRC_ZERO;
		end
	end

	always_comb begin
		case (src_s1)
			SRC_RAM:  src_byte = rd_data;
			SRC_MX:   src_byte = motion_x;
			SRC_MY:   src_byte = motion_y;
			SRC_PART: src_byte = fcrc_pkg::BYTE_W'(rep_part_q);
			default:  src_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q       <= '0;
			base_q       <= '0;
			rep_part_q   <= '0;
			rep_motion_q <= 1'b0;
			fetch_q      <= 1'b0;
			pos_q        <= '0;
			k_q          <= '0;
		end else if (start) begin
			fetch_q      <= 1'b1;
			pos_q        <= base_q;
			k_q          <= '0;
			rep_part_q   <= part_q;
			rep_motion_q <= motion_now;
			if (motion_now) begin
				part_q <= '0;
				base_q <= '0;
			end else begin
				part_q <= part_q + 1'b1;
				base_q <= base_q + fcrc_pkg::POS_W'(fcrc_pkg::REPORT_BYTES - 1);
			end
		end else if (fetch_q && s1_adv) begin
			pos_q <= pos_q + 1'b1;
			k_q   <= k_q + 1'b1;
			if (k_q == fcrc_pkg::KIDX_W'(fcrc_pkg::REPORT_BYTES - 1)) begin
				fetch_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			src_s1   <= SRC_ZERO;
			addr_s1  <= '0;
		end else if (fetch_q && s1_adv) begin
			valid_s1 <= 1'b1;
			src_s1   <= fetch_src;
			addr_s1  <= fetch_addr;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (byte_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= src_byte;
			out_last_q <= (src_s1 == SRC_PART);
		end
	end

	assign status.busy      = fetch_q || valid_s1;
	assign status.part_zero = (part_q == '0);
	assign byte_valid       = out_valid_q;
	assign report_byte      = out_byte_q;
	assign last             = out_last_q;

endmodule

`default_nettype wire

// File: rtl/core/frame_capture_report_chunker.sv
// Top level of the frame capture and report chunking block.
// Depends on fcrc_pkg, fcrc_pixel_store and fcrc_report_seq.
//
//   Channel   Handshake              Payload
//   command   cmd_valid/cmd_ready    op, sensor_byte, delta_x_in, delta_y_in
//   report    byte_valid/byte_ready  report_byte, last
//
// Start, pixel and motion commands are taken back to back.
// A report request streams REPORT_BYTES bytes at one byte per cycle while
// byte_ready is held high, from the memory read stage; the next command can
// be taken once the last byte has entered the output register.
// After reset the pixel memory is cleared one entry a cycle, FRAME_BYTES
// entries in all, with cmd_ready low. A stall on the report side holds the
// read stage in place.
`default_nettype none

module frame_capture_report_chunker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cmd_valid,
	output logic                                 cmd_ready,
	input  wire logic [1:0]                      op,
	input  wire logic [fcrc_pkg::BYTE_W-1:0]     sensor_byte,
	input  wire logic [fcrc_pkg::BYTE_W-1:0]     delta_x_in,
	input  wire logic [fcrc_pkg::BYTE_W-1:0]     delta_y_in,
	output logic                                 byte_valid,
	input  wire logic                            byte_ready,
	output logic      [fcrc_pkg::BYTE_W-1:0]     report_byte,
	output logic                                 last
);

	logic [fcrc_pkg::WPOS_W-1:0] wpos_q;
	logic [fcrc_pkg::BYTE_W-1:0] motion_x_q;
	logic [fcrc_pkg::BYTE_W-1:0] motion_y_q;

	fcrc_pkg::ram_req_t          ram_req;
	fcrc_pkg::seq_status_t       seq_status;
	logic [fcrc_pkg::BYTE_W-1:0] rd_data;
	logic [fcrc_pkg::ADDR_W-1:0] raddr;
	logic                        clearing;
	logic                        accept;
	logic                        capture;
	logic                        pixel_wr;

	assign cmd_ready = !clearing && !seq_status.busy;
	assign accept    = cmd_valid && cmd_ready;
	assign capture   = accept && seq_status.part_zero;
	assign pixel_wr  = capture && (op == fcrc_pkg::OP_PIXEL) &&
		sensor_byte[fcrc_pkg::VALID_BIT] &&
		(wpos_q < fcrc_pkg::WPOS_W'(fcrc_pkg::FRAME_BYTES));

	always_comb begin
		ram_req.we    = pixel_wr;
		ram_req.waddr = wpos_q[fcrc_pkg::ADDR_W-1:0];
		ram_req.wdata = sensor_byte << fcrc_pkg::PIXEL_SHIFT;
		ram_req.raddr = raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q     <= '0;
			motion_x_q <= '0;
			motion_y_q <= '0;
		end else if (capture) begin
			case (op)
				fcrc_pkg::OP_START: begin
					wpos_q <= '0;
				end
				fcrc_pkg::OP_PIXEL: begin
					if (pixel_wr) begin
						wpos_q <= wpos_q + 1'b1;
					end
				end
				fcrc_pkg::OP_MOTION: begin
					motion_x_q <= delta_x_in;
					motion_y_q <= delta_y_in;
				end
				default: begin
				end
			endcase
		end
	end

	fcrc_pixel_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (ram_req),
		.rd_data  (rd_data),
		.clearing (clearing)
	);

	fcrc_report_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept && (op == fcrc_pkg::OP_REPORT)),
		.motion_x    (motion_x_q),
		.motion_y    (motion_y_q),
		.rd_data     (rd_data),
		.raddr       (raddr),
		.status      (seq_status),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.report_byte (report_byte),
		.last        (last)
	);

endmodule

`default_nettype wire

// File: rtl/core/fcrc_checker.sv
// Port-level checker for the frame capture block, bound to the top level.
// Depends on fcrc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fcrc_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        cmd_valid,
	input wire logic                        cmd_ready,
	input wire logic [1:0]                  op,
	input wire logic [fcrc_pkg::BYTE_W-1:0] sensor_byte,
	input wire logic [fcrc_pkg::BYTE_W-1:0] delta_x_in,
	input wire logic [fcrc_pkg::BYTE_W-1:0] delta_y_in,
	input wire logic                        byte_valid,
	input wire logic                        byte_ready,
	input wire logic [fcrc_pkg::BYTE_W-1:0] report_byte,
	input wire logic                        last
);

	logic report_req;

	assign report_req = cmd_valid && cmd_ready && (op == fcrc_pkg::OP_REPORT);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, byte_valid && !byte_ready,
		byte_valid && $stable(report_byte) && $stable(last),
		"report byte changed while stalled")
	`ASSERT_NEXT(a_busy_after_req, clk, arst_n, report_req, !cmd_ready,
		"command taken right after a report request")
	`ASSERT_IMPLIES(a_ready_only_at_tail, clk, arst_n, cmd_ready, !byte_valid || last,
		"command port open with report bytes still pending")
	`ASSERT_NEXT(a_single_last, clk, arst_n, byte_valid && byte_ready && last,
		!(byte_valid && last), "two final report bytes in a row")

endmodule

bind frame_capture_report_chunker fcrc_checker u_fcrc_checker (.*);

`default_nettype wire
